### src/frame_dedup_with_refresh_top_defines.svh
// ----------------------------------------------------------------------------
// frame dedup assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef FRAME_DEDUP_WITH_REFRESH_TOP_DEFINES_SVH
`define FRAME_DEDUP_WITH_REFRESH_TOP_DEFINES_SVH

// assertion that is off while reset is held
`define FDR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("fdr assertion failed");

// assertion that is also checked through reset
`define FDR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fdr reset assertion failed");

`endif

### src/fdr_pkg.sv
// ----------------------------------------------------------------------------
// fdr_pkg
// shared types and constants of the frame dedup block
// ----------------------------------------------------------------------------
`default_nettype none

package fdr_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int FW_W       = 11;
    localparam int CNT_W      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WORDS  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESEND_AFTER = 4'd1;

    localparam logic [FW_W-1:0] FRAME_WORDS_RST = 11'd1024;

    typedef enum logic [1:0] {
        RSN_SUPPRESSED = 2'd0,
        RSN_CHANGED    = 2'd1,
        RSN_RESEND     = 2'd2
    } t_reason;

    typedef struct packed {
        logic [FW_W-1:0]  frame_words;
        logic [CNT_W-1:0] resend_after;
    } t_cfg;

    typedef struct packed {
        logic             forward;
        t_reason          reason;
        logic             frame_bank;
        logic [CNT_W-1:0] suppressed_run;
    } t_decision;

endpackage

`default_nettype wire

### src/fdr_if.sv
// ----------------------------------------------------------------------------
// fdr interfaces
// word input, decision output and register write channels
// ----------------------------------------------------------------------------
`default_nettype none

interface fdr_word_if #(
    parameter int WORD_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] data_word;

    modport source (output valid, output data_word, input ready);
    modport sink   (input valid, input data_word, output ready);
endinterface

interface fdr_dec_if;
    logic        valid;
    logic        ready;
    logic        forward;
    logic [1:0]  reason;
    logic        frame_bank;
    logic [15:0] suppressed_run;

    modport source (output valid, output forward, output reason, output frame_bank,
                    output suppressed_run, input ready);
    modport sink   (input valid, input forward, input reason, input frame_bank,
                    input suppressed_run, output ready);
endinterface

interface fdr_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/frame_dedup_with_refresh_top.sv
// ----------------------------------------------------------------------------
// frame_dedup_with_refresh_top
// path: last word is registered in the compare stage, decision in the output reg
// throughput: one word per cycle unless decisions stall, set by ram read/compare
// reset: synchronous, clears control; frame store is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module frame_dedup_with_refresh_top #(
    parameter int FRAME_MAX_WORDS = 1024,
    parameter int WORD_BITS       = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fdr_word_if.sink      i_in,
    fdr_dec_if.source     o_out,
    fdr_cfg_if.sink       i_cfg
);
    import fdr_pkg::*;

    t_cfg      r_cfg;
    logic      restart;
    logic      dec_valid;
    logic      dec_ready;
    t_decision dec;
    logic      r_out_valid;
    t_decision r_out;

    assign i_cfg.ready = 1'b1;
    assign restart     = i_cfg.valid && (i_cfg.index == CFG_FRAME_WORDS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_words  <= FRAME_WORDS_RST;
            r_cfg.resend_after <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FRAME_WORDS: begin
                    r_cfg.frame_words <= i_cfg.data[FW_W-1:0];
                end
                CFG_RESEND_AFTER: begin
                    r_cfg.resend_after <= i_cfg.data[CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    fdr_core #(
        .FRAME_MAX_WORDS (FRAME_MAX_WORDS),
        .WORD_BITS       (WORD_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_restart   (restart),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_word      (i_in.data_word),
        .o_dec_valid (dec_valid),
        .i_dec_ready (dec_ready),
        .o_dec       (dec)
    );

    // output register
    assign dec_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (dec_ready) begin
            r_out_valid <= dec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_ready && dec_valid) begin
            r_out <= dec;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.forward        = r_out.forward;
    assign o_out.reason         = r_out.reason;
    assign o_out.frame_bank     = r_out.frame_bank;
    assign o_out.suppressed_run = r_out.suppressed_run;

endmodule

`default_nettype wire

### src/fdr_ram.sv
// ----------------------------------------------------------------------------
// fdr_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module fdr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/fdr_core.sv
// ----------------------------------------------------------------------------
// fdr_core
// two bank frame store, word compare pipeline and per frame decision
// ----------------------------------------------------------------------------
`default_nettype none

module fdr_core #(
    parameter int FRAME_MAX_WORDS = 1024,
    parameter int WORD_BITS       = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fdr_pkg::t_cfg        i_cfg,
    input  logic                 i_restart,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [WORD_BITS-1:0] i_word,
    output logic                 o_dec_valid,
    input  logic                 i_dec_ready,
    output fdr_pkg::t_decision   o_dec
);
    import fdr_pkg::*;

    localparam int POS_W = (FRAME_MAX_WORDS > 1) ? $clog2(FRAME_MAX_WORDS) : 1;
    localparam int LEN_W = $clog2(FRAME_MAX_WORDS + 1);

    logic [LEN_W-1:0]     len;
    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     n_pos;
    logic                 s1_last;
    logic                 accept;
    logic                 s2_go;

    logic                 r_s2_valid;
    logic [WORD_BITS-1:0] r_s2_word;
    logic [POS_W-1:0]     r_s2_pos;
    logic                 r_s2_last;
    logic                 r_byp_hit;
    logic                 r_byp_bank;
    logic [WORD_BITS-1:0] r_byp_data;

    logic                 r_sent_bank;
    logic                 r_have_sent;
    logic                 r_mismatch;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;

    logic                 pending;
    logic [WORD_BITS-1:0] q0;
    logic [WORD_BITS-1:0] q1;
    logic [WORD_BITS-1:0] old_word;
    logic                 mism;
    logic                 changed;
    logic                 resend;
    logic                 fwd;

    // effective frame length
    always_comb begin
        if (i_cfg.frame_words == '0) begin
            len = LEN_W'(1);
        end else if (32'(i_cfg.frame_words) > 32'(FRAME_MAX_WORDS)) begin
            len = LEN_W'(FRAME_MAX_WORDS);
        end else begin
            len = LEN_W'(i_cfg.frame_words);
        end
    end

    assign s1_last = (32'(r_pos) + 32'd1) >= 32'(len);
    assign n_pos   = s1_last ? '0 : r_pos + POS_W'(1);

    assign s2_go   = r_s2_valid && (!r_s2_last || i_dec_ready);
    assign o_ready = !r_s2_valid || s2_go;
    assign accept  = i_valid && o_ready;
    assign pending = ~r_sent_bank;

    fdr_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (FRAME_MAX_WORDS)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (s2_go && !pending),
        .i_waddr (r_s2_pos),
        .i_wdata (r_s2_word),
        .i_re    (accept),
        .i_raddr (r_pos),
        .o_rdata (q0)
    );

    fdr_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (FRAME_MAX_WORDS)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (s2_go && pending),
        .i_waddr (r_s2_pos),
        .i_wdata (r_s2_word),
        .i_re    (accept),
        .i_raddr (r_pos),
        .o_rdata (q1)
    );

    // compare against last forwarded frame, with write forwarding
    always_comb begin
        if (r_byp_hit && (r_byp_bank == r_sent_bank)) begin
            old_word = r_byp_data;
        end else begin
            old_word = r_sent_bank ? q1 : q0;
        end
        mism    = r_mismatch || (old_word != r_s2_word);
        changed = !r_have_sent || mism;
        resend  = (i_cfg.resend_after != '0) && (r_cnt >= i_cfg.resend_after);
        fwd     = changed || resend;
        n_cnt   = (r_cnt != '1) ? r_cnt + CNT_W'(1) : r_cnt;
    end

    assign o_dec_valid          = r_s2_valid && r_s2_last;
    assign o_dec.forward        = fwd;
    assign o_dec.reason         = changed ? RSN_CHANGED : (resend ? RSN_RESEND : RSN_SUPPRESSED);
    assign o_dec.frame_bank     = pending;
    assign o_dec.suppressed_run = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_byp_hit   <= 1'b0;
            r_sent_bank <= 1'b0;
            r_have_sent <= 1'b0;
            r_mismatch  <= 1'b0;
            r_cnt       <= '0;
            r_pos       <= '0;
        end else begin
            if (accept) begin
                r_s2_valid <= 1'b1;
                r_byp_hit  <= s2_go && (r_s2_pos == r_pos);
            end else if (s2_go) begin
                r_s2_valid <= 1'b0;
            end
            if (i_restart) begin
                r_pos       <= '0;
                r_mismatch  <= 1'b0;
                r_have_sent <= 1'b0;
                r_cnt       <= '0;
            end else begin
                if (accept) begin
                    r_pos <= n_pos;
                end
                if (s2_go) begin
                    if (r_s2_last) begin
                        r_mismatch <= 1'b0;
                        if (fwd) begin
                            r_sent_bank <= pending;
                            r_have_sent <= 1'b1;
                            r_cnt       <= '0;
                        end else begin
                            r_cnt <= n_cnt;
                        end
                    end else begin
                        r_mismatch <= mism;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_word  <= i_word;
            r_s2_pos   <= r_pos;
            r_s2_last  <= s1_last;
            r_byp_bank <= pending;
            r_byp_data <= r_s2_word;
        end
    end

endmodule

`default_nettype wire

### src/fdr_checker.sv
// ----------------------------------------------------------------------------
// fdr_checker
// port level checks of the frame dedup block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_dedup_with_refresh_top_defines.svh"

module fdr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_forward,
    input logic [1:0]  i_reason,
    input logic        i_frame_bank,
    input logic [15:0] i_run
);
    import fdr_pkg::*;

    logic [19:0] out_fields;
    logic        reason_known;
    logic        forward_match;

    assign out_fields    = {i_forward, i_reason, i_frame_bank, i_run};
    assign reason_known  = (i_reason == RSN_SUPPRESSED) || (i_reason == RSN_CHANGED) ||
                           (i_reason == RSN_RESEND);
    assign forward_match = (i_forward == (i_reason != RSN_SUPPRESSED));

    `FDR_ASSERT_ALWAYS(a_reset_no_result, i_clk, !i_rst_n |=> !i_out_valid)

    `FDR_ASSERT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(out_fields))

    `FDR_ASSERT(a_forward_reason, i_clk, i_rst_n, i_out_valid |-> forward_match && reason_known)

    `FDR_ASSERT(a_resend_run, i_clk, i_rst_n, i_out_valid && (i_reason == RSN_RESEND) |-> i_run != 16'd0)

endmodule

bind frame_dedup_with_refresh_top fdr_checker u_fdr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_forward    (o_out.forward),
    .i_reason     (o_out.reason),
    .i_frame_bank (o_out.frame_bank),
    .i_run        (o_out.suppressed_run)
);

`default_nettype wire

### bench/tb_frame_dedup_with_refresh_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_dedup_with_refresh_top
// streams frames of words into the dedup block and checks every forward or
// suppress decision against a shadow model of the two-bank frame store; a
// short directed walk with hand-computed decisions comes first, then random
// phases of repeated, altered and fresh frames under many length and resend
// settings, with stalls on both channels
// ----------------------------------------------------------------------------

module tb_frame_dedup_with_refresh_top;

    import fdr_pkg::*;

    localparam int FRAME_MAX      = 1024;
    localparam int RANDOM_ITEMS   = 850;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 40;
    localparam int LONG_TAIL      = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = 4'h2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = 4'hF;

    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          val;
        bit                   typed;
        t_decision            dec;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    fdr_word_if #(.WORD_BITS(32)) in_if ();
    fdr_dec_if                    out_if ();
    fdr_cfg_if                    cfg_if ();

    frame_dedup_with_refresh_top #(
        .FRAME_MAX_WORDS (FRAME_MAX),
        .WORD_BITS       (32)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // shadow state of the block
    bit [31:0]       shadow_store [0:2*FRAME_MAX-1];
    bit              p_sent_bank;
    bit              p_have_sent;
    int              p_word_pos;
    bit              p_mismatch;
    bit [CNT_W-1:0]  p_supp_count;
    bit [FW_W-1:0]   p_frame_words = FRAME_WORDS_RST;
    bit [CNT_W-1:0]  p_resend_after;

    t_decision       due_decisions [$];
    t_stim_row       stim_rows [$];
    logic [31:0]     last_frame [$];

    // sideband that travels with each word request
    bit              tag_typed;
    t_decision       tag_dec;

    int  error_count;
    int  decision_count;
    int  stall_cycles;
    bit  rst_done;
    bit  quiet;
    bit  sender_idle_on;
    bit  sink_idle_on;
    bit  hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) $display("ERROR: %s", msg);
    endtask

    function automatic int frame_len(input bit [FW_W-1:0] fw);
        if (fw == 0) return 1;
        if (fw > FRAME_MAX) return FRAME_MAX;
        return int'(fw);
    endfunction

    function automatic t_decision mk_dec(input bit f, input t_reason r, input bit b,
                                         input int n);
        t_decision d;
        d.forward        = f;
        d.reason         = r;
        d.frame_bank     = b;
        d.suppressed_run = n[CNT_W-1:0];
        return d;
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        t_stim_row r;
        r.is_reg = 1'b1; r.idx = idx; r.val = {16'd0, val}; r.typed = 1'b0; r.dec = '0;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_word(input logic [31:0] w);
        t_stim_row r;
        r.is_reg = 1'b0; r.idx = '0; r.val = w; r.typed = 1'b0; r.dec = '0;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_last(input logic [31:0] w, input t_decision d);
        t_stim_row r;
        r.is_reg = 1'b0; r.idx = '0; r.val = w; r.typed = 1'b1; r.dec = d;
        stim_rows.push_back(r);
    endfunction

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        if (idx == CFG_FRAME_WORDS) begin
            p_frame_words = val[FW_W-1:0];
            p_word_pos    = 0;
            p_mismatch    = 1'b0;
            p_have_sent   = 1'b0;
            p_supp_count  = '0;
        end else if (idx == CFG_RESEND_AFTER) begin
            p_resend_after = val;
        end
    endtask

    task automatic predict_decision(input bit [31:0] w, output bit made, output t_decision d);
        int len;
        int pos;
        bit pend;
        bit changed;
        bit resend;
        len  = frame_len(p_frame_words);
        pend = ~p_sent_bank;
        pos  = p_word_pos;
        if (pos >= FRAME_MAX) pos = FRAME_MAX - 1;
        if (shadow_store[p_sent_bank * FRAME_MAX + pos] != w) p_mismatch = 1'b1;
        shadow_store[pend * FRAME_MAX + pos] = w;
        made = 1'b0;
        d    = '0;
        if (pos + 1 < len) begin
            p_word_pos = pos + 1;
        end else begin
            changed = !p_have_sent || p_mismatch;
            resend  = (p_resend_after != 0) && (p_supp_count >= p_resend_after);
            made             = 1'b1;
            d.forward        = changed || resend;
            d.reason         = changed ? RSN_CHANGED : (resend ? RSN_RESEND : RSN_SUPPRESSED);
            d.frame_bank     = pend;
            d.suppressed_run = p_supp_count;
            if (changed || resend) begin
                p_sent_bank  = pend;
                p_have_sent  = 1'b1;
                p_supp_count = '0;
            end else if (p_supp_count != '1) begin
                p_supp_count = p_supp_count + 1'b1;
            end
            p_word_pos = 0;
            p_mismatch = 1'b0;
        end
    endtask

    // prediction on accepted requests, checking on accepted decisions
    always @(posedge i_clk) begin : monitor
        bit        made;
        t_decision pred;
        t_decision want;
        if (rst_done) begin
            if (cfg_if.valid && cfg_if.ready) apply_reg(cfg_if.index, cfg_if.data);
            if (in_if.valid && in_if.ready) begin
                predict_decision(in_if.data_word, made, pred);
                if (made) due_decisions.push_back(tag_typed ? tag_dec : pred);
            end
            if (out_if.valid && out_if.ready) begin
                decision_count++;
                if (due_decisions.size() == 0) begin
                    report_error($sformatf("decision %0d arrived with none due", decision_count));
                end else begin
                    want = due_decisions.pop_front();
                    if (out_if.forward !== want.forward || out_if.reason !== want.reason ||
                        out_if.frame_bank !== want.frame_bank ||
                        out_if.suppressed_run !== want.suppressed_run)
                        report_error($sformatf(
                            "decision %0d: fwd %b/%b reason %0d/%0d bank %b/%b run %0d/%0d",
                            decision_count, out_if.forward, want.forward, out_if.reason,
                            want.reason, out_if.frame_bank, want.frame_bank,
                            out_if.suppressed_run, want.suppressed_run));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_done) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= WATCHDOG_LIMIT) begin
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    // decision side ready
    initial begin : sink_ready
        int n;
        out_if.ready = 1'b0;
        wait (rst_done);
        forever begin
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && sink_idle_on && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 1'b0;
                n = $urandom_range(1, 5);
                repeat (n) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic drain_decisions();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (due_decisions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        drain_decisions();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_word(input logic [31:0] w, input bit typed, input t_decision td);
        int n;
        in_if.valid     <= 1'b1;
        in_if.data_word <= w;
        tag_typed       <= typed;
        tag_dec         <= td;
        do @(posedge i_clk); while (!in_if.ready);
        if (!quiet && sender_idle_on && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            n = $urandom_range(1, 5);
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // one setting, then a run of frames; returns the number of words sent
    task automatic run_phase(input logic [15:0] fw_val, input logic [15:0] ra_val,
                             input int frames, input int repeat_pct, input bit partial_tail,
                             input bit pressure, output int sent);
        int          len;
        int          kind;
        int          spot;
        int          tail;
        logic [31:0] cur [$];
        sent = 0;
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_FRAME_WORDS, fw_val);
            write_reg(CFG_RESEND_AFTER, ra_val);
        end else begin
            write_reg(CFG_RESEND_AFTER, ra_val);
            write_reg(CFG_FRAME_WORDS, fw_val);
        end
        len = frame_len(fw_val[FW_W-1:0]);
        if (pressure) hold_req = 1'b1;
        for (int f = 0; f < frames; f++) begin
            kind = $urandom_range(0, 99);
            cur.delete();
            if (last_frame.size() == len && f > 0 && kind < repeat_pct + 20) begin
                cur = last_frame;
                if (kind >= repeat_pct) begin
                    spot = $urandom_range(0, len - 1);
                    cur[spot] = cur[spot] ^ (32'h1 << $urandom_range(0, 31));
                end
            end else begin
                for (int k = 0; k < len; k++) cur.push_back(rand_word());
            end
            foreach (cur[k]) send_word(cur[k], 1'b0, '0);
            sent += len;
            last_frame = cur;
            if (!pressure && $urandom_range(0, 9) == 0)
                write_reg(CFG_RESEND_AFTER, 16'($urandom_range(0, 4)));
        end
        // broken frame, cut off by the next length write
        if (partial_tail && len > 1) begin
            tail = $urandom_range(1, len - 1);
            for (int k = 0; k < tail; k++) send_word(rand_word(), 1'b0, '0);
            sent += tail;
        end
    endtask

    initial begin : stimulus
        int          random_items;
        int          phase;
        int          sent;
        logic [15:0] fw_val;
        logic [15:0] ra_val;

        in_if.valid     = 1'b0;
        in_if.data_word = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;
        tag_typed       = 1'b0;
        tag_dec         = '0;
        sender_idle_on  = 1'b1;
        sink_idle_on    = 1'b1;
        i_rst_n         = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;

        // single-word frames, first frame, repeats, change
        add_reg(CFG_FRAME_WORDS, 16'd1);
        add_last(32'h0000_0000, mk_dec(1'b1, RSN_CHANGED,    1'b1, 0));
        add_last(32'h0000_0000, mk_dec(1'b0, RSN_SUPPRESSED, 1'b0, 0));
        add_last(32'h0000_0000, mk_dec(1'b0, RSN_SUPPRESSED, 1'b0, 1));
        add_last(32'hFFFF_FFFF, mk_dec(1'b1, RSN_CHANGED,    1'b0, 2));
        // periodic resend
        add_reg(CFG_RESEND_AFTER, 16'd2);
        add_last(32'hFFFF_FFFF, mk_dec(1'b0, RSN_SUPPRESSED, 1'b1, 0));
        add_last(32'hFFFF_FFFF, mk_dec(1'b0, RSN_SUPPRESSED, 1'b1, 1));
        add_last(32'hFFFF_FFFF, mk_dec(1'b1, RSN_RESEND,     1'b1, 2));
        add_last(32'hFFFF_FFFF, mk_dec(1'b0, RSN_SUPPRESSED, 1'b0, 0));
        // zero length acts as one and restarts
        add_reg(CFG_FRAME_WORDS, 16'd0);
        add_last(32'hFFFF_FFFF, mk_dec(1'b1, RSN_CHANGED,    1'b0, 0));
        // three-word frames
        add_reg(CFG_FRAME_WORDS, 16'd3);
        add_reg(CFG_RESEND_AFTER, 16'd0);
        add_word(32'h0000_0001);
        add_word(32'h0000_0002);
        add_last(32'h0000_0003, mk_dec(1'b1, RSN_CHANGED,    1'b1, 0));
        add_word(32'h0000_0001);
        add_word(32'h0000_0002);
        add_last(32'h0000_0003, mk_dec(1'b0, RSN_SUPPRESSED, 1'b0, 0));
        // length write mid-frame, upper bits masked
        add_word(32'h0000_0001);
        add_word(32'h8000_0000);
        add_reg(CFG_FRAME_WORDS, 16'h0803);
        add_word(32'h0000_0001);
        add_word(32'h0000_0002);
        add_last(32'h0000_0003, mk_dec(1'b1, RSN_CHANGED,    1'b0, 0));
        // unknown register indexes change nothing
        add_reg(CFG_IDX_UNUSED_HI, 16'hFFFF);
        add_reg(CFG_IDX_UNUSED_LO, 16'h0001);
        add_word(32'h0000_0001);
        add_word(32'h0000_0002);
        add_last(32'h0000_0003, mk_dec(1'b0, RSN_SUPPRESSED, 1'b1, 0));
        add_word(32'h0000_0001);
        add_word(32'h0000_0002);
        add_last(32'h0000_0003, mk_dec(1'b0, RSN_SUPPRESSED, 1'b1, 1));

        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_reg)
                write_reg(stim_rows[i].idx, stim_rows[i].val[15:0]);
            else
                send_word(stim_rows[i].val, stim_rows[i].typed, stim_rows[i].dec);
        end
        last_frame.delete();

        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS) begin
            quiet          = (random_items >= RANDOM_ITEMS - 150);
            sender_idle_on = ($urandom_range(0, 3) != 0);
            sink_idle_on   = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 7))
                0, 1:    ra_val = 16'd0;
                2, 3, 4: ra_val = 16'($urandom_range(1, 4));
                5:       ra_val = 16'($urandom_range(5, 40));
                6:       ra_val = 16'hFFFF;
                default: ra_val = 16'($urandom);
            endcase
            case ($urandom_range(0, 15))
                0:       fw_val = 16'd0;
                1, 2, 3, 4, 5, 6: fw_val = 16'd1;
                7, 8, 9, 10, 11:  fw_val = 16'($urandom_range(2, 4));
                12, 13, 14:       fw_val = 16'($urandom_range(5, 12));
                default: fw_val = 16'($urandom_range(13, 40));
            endcase
            fw_val[15:FW_W] = 5'($urandom);
            if (phase == 2) begin
                // long decision hold-off while words keep coming
                run_phase(16'd1, 16'd2, 60, 60, 1'b0, 1'b1, sent);
                random_items += sent;
            end else if (phase == 4) begin
                // oversized length acts as the maximum, frame cut off by the next length write
                write_reg(CFG_FRAME_WORDS, 16'd1025);
                for (int k = 0; k < LONG_TAIL; k++) send_word(rand_word(), 1'b0, '0);
                random_items += LONG_TAIL;
            end else begin
                run_phase(fw_val, ra_val, $urandom_range(4, 16), 60,
                          $urandom_range(0, 5) == 0, 1'b0, sent);
                random_items += sent;
            end
            phase++;
        end

        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (due_decisions.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        while (due_decisions.size() != 0) begin
            void'(due_decisions.pop_front());
            report_error("decision still due at end of run");
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
